FILE: hw/rtl/upf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upf_pkg
// Types and constants shared by the packet framer modules.
// ----------------------------------------------------------------------------
package upf_pkg;

  localparam int unsigned MaxBurst = 6;
  localparam int unsigned CountW   = $clog2(MaxBurst + 1);

  localparam logic [7:0] StartMark = 8'h3C;
  localparam logic [1:0] WeightMask = 2'b11;

  localparam logic ActHeader = 1'b0;
  localparam logic ActData   = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] command;
    logic [7:0] arg_len;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       protocol_error;
  } out_item_t;

  // Bytes produced by one request; entry 0 goes out first.
  typedef struct packed {
    logic [MaxBurst-1:0][7:0] bytes;
    logic [CountW-1:0]        len;
    logic                     err;
    logic                     fend;
  } burst_t;

endpackage

FILE: hw/rtl/upf_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upf_framer_core
// Frame state and running checks; builds the byte burst for one request.
// ----------------------------------------------------------------------------
module upf_framer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  upf_pkg::in_item_t item,
  output upf_pkg::burst_t   burst
);

  logic       frame_open, frame_open_next;
  logic [7:0] remaining, remaining_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] xor_check, xor_check_next;
  logic [7:0] weighted_check, weighted_check_next;

  logic [7:0] term_sum;
  logic [2:0] term_weight;
  logic [10:0] term_product;
  logic [7:0] header_sum;

  always_comb begin
    term_sum     = item.data_byte + byte_index;
    term_weight  = {1'b0, byte_index[1:0] & upf_pkg::WeightMask} + 3'd1;
    term_product = term_sum * term_weight;
    header_sum   = item.command + item.arg_len;

    frame_open_next     = frame_open;
    remaining_next      = remaining;
    byte_index_next     = byte_index;
    xor_check_next      = xor_check;
    weighted_check_next = weighted_check;

    burst       = '0;

    if (item.action == upf_pkg::ActHeader) begin
      xor_check_next      = item.command ^ item.arg_len;
      weighted_check_next = 8'd0;
      byte_index_next     = 8'd0;
      remaining_next      = item.arg_len;
      frame_open_next     = 1'b1;
      burst.bytes[0] = upf_pkg::StartMark;
      burst.bytes[1] = item.command;
      burst.bytes[2] = item.arg_len;
      burst.bytes[3] = header_sum;
      burst.bytes[4] = xor_check_next;
      burst.bytes[5] = 8'd0;
      burst.err      = frame_open;
      if (item.arg_len == 8'd0) begin
        // An empty packet closes straight after its header.
        frame_open_next = 1'b0;
        burst.len       = upf_pkg::CountW'(6);
        burst.fend      = 1'b1;
      end else begin
        burst.len = upf_pkg::CountW'(4);
      end
    end else if (!frame_open) begin
      burst.bytes[0] = 8'd0;
      burst.len      = upf_pkg::CountW'(1);
      burst.err      = 1'b1;
    end else begin
      xor_check_next      = xor_check ^ item.data_byte;
      weighted_check_next = weighted_check + term_product[7:0];
      byte_index_next     = byte_index + 8'd1;
      remaining_next      = remaining - 8'd1;
      burst.bytes[0] = item.data_byte;
      burst.bytes[1] = xor_check_next;
      burst.bytes[2] = weighted_check_next;
      if (remaining_next == 8'd0) begin
        frame_open_next = 1'b0;
        byte_index_next = 8'd0;
        burst.len       = upf_pkg::CountW'(3);
        burst.fend      = 1'b1;
      end else begin
        burst.len = upf_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open     <= 1'b0;
      remaining      <= 8'd0;
      byte_index     <= 8'd0;
      xor_check      <= 8'd0;
      weighted_check <= 8'd0;
    end else if (load) begin
      frame_open     <= frame_open_next;
      remaining      <= remaining_next;
      byte_index     <= byte_index_next;
      xor_check      <= xor_check_next;
      weighted_check <= weighted_check_next;
    end
  end

endmodule

FILE: hw/rtl/uart_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_packet_framer
// Frames header and data requests into a checked byte stream.
// ----------------------------------------------------------------------------
// Each accepted request is turned combinationally into a burst of one to six
// bytes held in an output shift buffer, which then sends one byte per cycle
// while result_ready is high: a header gives four bytes (six for an empty
// packet), a data byte one byte (three when it closes the packet), and a data
// byte with no packet open one byte. The single-byte output port sets the rate;
// a new request is taken in the same cycle as the last byte of the previous
// burst leaves, so the stream runs without gaps while the consumer keeps up.
module uart_packet_framer (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  upf_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output upf_pkg::out_item_t result
);

  upf_pkg::burst_t burst;

  logic [upf_pkg::MaxBurst-1:0][7:0] pending;
  logic [upf_pkg::CountW-1:0]        count;
  logic                              pending_err;
  logic                              pending_fend;

  logic item_take;
  logic result_take;

  assign result_valid = (count != '0);
  assign result_take  = result_valid && result_ready;
  assign item_ready   = (count == '0) ||
                        ((count == upf_pkg::CountW'(1)) && result_ready);
  assign item_take    = item_valid && item_ready;

  upf_framer_core u_core (
    .clk   (clk),
    .rst   (rst),
    .load  (item_take),
    .item  (item),
    .burst (burst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (item_take) begin
      count <= burst.len;
    end else if (result_take) begin
      count <= count - upf_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      pending      <= burst.bytes;
      pending_err  <= burst.err;
      pending_fend <= burst.fend;
    end else if (result_take) begin
      for (int i = 0; i < upf_pkg::MaxBurst - 1; i++) begin
        pending[i] <= pending[i+1];
      end
    end
  end

  always_comb begin
    result.out_byte       = pending[0];
    result.run_last       = (count == upf_pkg::CountW'(1));
    result.frame_end      = pending_fend && (count == upf_pkg::CountW'(1));
    result.protocol_error = pending_err;
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= upf_pkg::CountW'(upf_pkg::MaxBurst))
    else $error("output buffer holds more bytes than a burst");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    item_take |=> result_valid)
    else $error("accepted request produced no output byte");

  a_fend_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_end |-> result.run_last)
    else $error("frame end not on the last byte of a burst");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    item_take |-> (count == '0) || (result_take && count == upf_pkg::CountW'(1)))
    else $error("request accepted over undelivered bytes");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UART packet framer.
// ----------------------------------------------------------------------------
// Header and data requests are queued up front: a directed opening covering
// empty packets, full-range bytes, aborted frames and stray data, then random
// packets with the odd truncated frame and stray data byte. A clocked driver
// feeds them in bursts. A clocked monitor compares every output byte with the
// stream predicted when the request was accepted. The consumer stalls on its
// own pattern and twice holds off for a long stretch.
module testbench;

  typedef enum int {RxSteady, RxCoinFlip, RxEveryFourth, RxSparse} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  upf_pkg::in_item_t  item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  upf_pkg::out_item_t result;

  upf_pkg::in_item_t  pending_requests[$];
  upf_pkg::out_item_t expected_bytes[$];
  int        items_total = 0;
  int        items_accepted = 0;
  int        error_count = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        rx_cycles = 0;
  int        hold_left = 0;
  rx_mode_t  rx_mode = RxSteady;

  // Predicted framer state.
  logic       fr_open = 1'b0;
  logic [7:0] fr_remaining = '0;
  logic [7:0] fr_index = '0;
  logic [7:0] fr_xor = '0;
  logic [7:0] fr_weighted = '0;

  uart_packet_framer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic upf_pkg::in_item_t header_req(logic [7:0] cmd, logic [7:0] cnt);
    upf_pkg::in_item_t r;
    r.action    = upf_pkg::ActHeader;
    r.command   = cmd;
    r.arg_len   = cnt;
    r.data_byte = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic upf_pkg::in_item_t data_req(logic [7:0] dat);
    upf_pkg::in_item_t r;
    r.action    = upf_pkg::ActData;
    r.command   = 8'($urandom_range(0, 255));
    r.arg_len   = 8'($urandom_range(0, 255));
    r.data_byte = dat;
    return r;
  endfunction

  function automatic upf_pkg::out_item_t stream_byte(logic [7:0] b, logic fend, logic err);
    upf_pkg::out_item_t o;
    o.out_byte       = b;
    o.run_last       = 1'b0;
    o.frame_end      = fend;
    o.protocol_error = err;
    return o;
  endfunction

  // Works out the bytes one request produces and advances the predicted state.
  function automatic void predict_framing(upf_pkg::in_item_t req);
    upf_pkg::out_item_t seq[6];
    int        n;
    int        w;
    logic      err;
    logic      closes;
    n      = 0;
    err    = 1'b0;
    closes = 1'b0;
    if (req.action == upf_pkg::ActHeader) begin
      // A header inside an open frame abandons it and is flagged throughout.
      err    = fr_open;
      seq[0] = stream_byte(upf_pkg::StartMark, 1'b0, err);
      seq[1] = stream_byte(req.command, 1'b0, err);
      seq[2] = stream_byte(req.arg_len, 1'b0, err);
      seq[3] = stream_byte(req.command + req.arg_len, 1'b0, err);
      n = 4;
      fr_xor       = req.command ^ req.arg_len;
      fr_weighted  = '0;
      fr_index     = '0;
      fr_remaining = req.arg_len;
      fr_open      = 1'b1;
      closes       = (req.arg_len == 8'd0);
    end else if (!fr_open) begin
      seq[0] = stream_byte(8'h00, 1'b0, 1'b1);
      n = 1;
    end else begin
      w = ((int'(req.data_byte) + int'(fr_index)) *
           (int'(fr_index[1:0] & upf_pkg::WeightMask) + 1)) & 255;
      seq[0] = stream_byte(req.data_byte, 1'b0, 1'b0);
      n = 1;
      fr_xor       = fr_xor ^ req.data_byte;
      fr_weighted  = fr_weighted + 8'(w);
      fr_index     = fr_index + 8'd1;
      fr_remaining = fr_remaining - 8'd1;
      closes       = (fr_remaining == 8'd0);
    end
    if (closes) begin
      seq[n]     = stream_byte(fr_xor, 1'b0, err);
      seq[n + 1] = stream_byte(fr_weighted, 1'b1, err);
      n = n + 2;
      fr_open      = 1'b0;
      fr_remaining = '0;
      fr_index     = '0;
    end
    seq[n - 1].run_last = 1'b1;
    for (int k = 0; k < n; k++) expected_bytes.push_back(seq[k]);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        predict_framing(item);
        items_accepted++;
      end
      if (!item_valid || item_ready) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          item_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          item       <= pending_requests.pop_front();
          item_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Consumer: its own stall pattern, plus two long hold-offs that back the
  // framer up into its request side.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == 150 || rx_cycles == 900) hold_left = 80;
      if (rx_cycles % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RxSteady:      result_ready <= 1'b1;
          RxCoinFlip:    result_ready <= 1'($urandom_range(0, 1));
          RxEveryFourth: result_ready <= (rx_cycles % 4 != 0);
          default:       result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    upf_pkg::out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", result.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (result.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    result.out_byte, want.out_byte));
        if (result.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b",
                                    result.run_last, want.run_last));
        if (result.frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end %b, want %b",
                                    result.frame_end, want.frame_end));
        if (result.protocol_error !== want.protocol_error)
          report_mismatch($sformatf("protocol_error %b, want %b",
                                    result.protocol_error, want.protocol_error));
      end
    end
  end

  initial begin
    int rand_items;
    int pick;
    int cnt;
    int sent;
    rand_items = 0;

    // Stray data straight after reset, then empty packets at both extremes.
    pending_requests.push_back(data_req(8'hFF));
    pending_requests.push_back(header_req(8'h00, 8'h00));
    pending_requests.push_back(header_req(8'hFF, 8'h00));
    // A complete short packet, then stray data once it has closed.
    pending_requests.push_back(header_req(8'hA5, 8'h03));
    pending_requests.push_back(data_req(8'h00));
    pending_requests.push_back(data_req(8'hFF));
    pending_requests.push_back(data_req(8'h5A));
    pending_requests.push_back(data_req(8'h81));
    // Packets cut short by a new header.
    pending_requests.push_back(header_req(8'h12, 8'h05));
    pending_requests.push_back(data_req(8'h01));
    pending_requests.push_back(data_req(8'h02));
    pending_requests.push_back(header_req(8'hFF, 8'h01));
    pending_requests.push_back(data_req(8'hFF));
    pending_requests.push_back(header_req(8'h7E, 8'hFF));
    pending_requests.push_back(data_req(8'h80));
    pending_requests.push_back(data_req(8'h7F));
    pending_requests.push_back(data_req(8'h33));
    pending_requests.push_back(data_req(8'hC4));
    pending_requests.push_back(header_req(8'h00, 8'h04));
    pending_requests.push_back(data_req(8'hAA));
    pending_requests.push_back(data_req(8'h55));
    pending_requests.push_back(data_req(8'h0F));
    pending_requests.push_back(data_req(8'hF0));

    // Mostly well-formed packets; some truncated, some stray data between.
    while (rand_items < 137) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_requests.push_back(data_req(8'($urandom_range(0, 255))));
        rand_items++;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 14)      cnt = $urandom_range(0, 6);
        else if (pick < 19) cnt = $urandom_range(7, 24);
        else                cnt = $urandom_range(200, 255);
        sent = cnt;
        if (cnt > 30 || $urandom_range(0, 7) == 0)
          sent = $urandom_range(0, (cnt < 8) ? cnt : 8);
        pending_requests.push_back(header_req(8'($urandom_range(0, 255)), 8'(cnt)));
        for (int k = 0; k < sent; k++)
          pending_requests.push_back(data_req(8'($urandom_range(0, 255))));
        rand_items += 1 + sent;
      end
    end
    items_total = pending_requests.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted != items_total) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
